// ===== rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and constants
// Field types, datapath widths, register indexes and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

  localparam int Q_W       = 16;
  localparam int CFG_W     = 12;
  localparam int IDX_W     = 2;
  localparam int PROD_W    = 32;
  localparam int ARG_W     = 34;
  localparam int PA_W      = 33;
  localparam int SQ_DIGITS = 28;
  localparam int SQ_W      = 2 * SQ_DIGITS;
  localparam int CW        = 36;
  localparam int ZW        = 26;
  localparam int FW        = 28;
  localparam int MAX_STAGES          = 24;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [IDX_W-1:0] REG_ROLL_OFFSET  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PITCH_OFFSET = 2'd1;

  localparam logic signed [CFG_W-1:0] ROLL_OFFSET_RST  = 12'sd77;
  localparam logic signed [CFG_W-1:0] PITCH_OFFSET_RST = -12'sd448;

  localparam logic signed [ZW-1:0] DEG90   = 26'sd5898240;
  localparam logic signed [FW-1:0] DEG90_F = 28'sd5898240;

  typedef struct packed {
    logic signed [Q_W-1:0] quat_real;
    logic signed [Q_W-1:0] quat_i;
    logic signed [Q_W-1:0] quat_j;
    logic signed [Q_W-1:0] quat_k;
  } quat_in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] roll_deg;
    logic signed [Q_W-1:0] pitch_deg;
    logic signed [Q_W-1:0] yaw_deg;
  } euler_out_t;

  typedef struct packed {
    logic signed [ARG_W-1:0] ry;
    logic signed [ARG_W-1:0] rx;
    logic signed [ARG_W-1:0] yy;
    logic signed [ARG_W-1:0] yx;
    logic        [PA_W-1:0]  pa;
    logic        [PA_W-1:0]  pb;
  } front_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117305;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [Q_W-1:0] finish(input logic signed [FW-1:0] ang,
                                                   input logic signed [CFG_W-1:0] off);
    localparam logic signed [FW-1:0] RND     = 28'sd256;
    localparam logic signed [FW-1:0] SAT_MAX = 28'sd32767;
    localparam logic signed [FW-1:0] SAT_MIN = -28'sd32768;
    logic signed [FW-1:0] v;
    v = ((ang + RND) >>> 9) + FW'(off);
    if (v > SAT_MAX) v = SAT_MAX;
    if (v < SAT_MIN) v = SAT_MIN;
    return v[Q_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/q2e_front.sv =====
// ----------------------------------------------------------------------------
// q2e_front: input stage and product terms
// Registers the quaternion, forms the nine products, then sums them into
// the atan2 and sqrt arguments for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_front import q2e_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire quat_in_t quat,
  input  wire logic     q_full,
  output logic          q_push,
  output front_t        q_data
);

  logic     va, vb, en;
  quat_in_t qa;
  logic signed [PROD_W-1:0] p_ri, p_jk, p_ii, p_jj, p_rk, p_ij, p_kk, p_rj, p_ik;
  logic signed [PA_W+1:0]   t, pa, pb;

  localparam logic signed [ARG_W-1:0] ONE_A = 34'sd268435456;
  localparam logic signed [PA_W+1:0]  ONE_P = 35'sd268435456;

  assign en     = !vb || !q_full;
  assign full   = !en;
  assign q_push = vb && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else if (en) begin
      va <= push;
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa   <= quat;
      p_ri <= qa.quat_real * qa.quat_i;
      p_jk <= qa.quat_j * qa.quat_k;
      p_ii <= qa.quat_i * qa.quat_i;
      p_jj <= qa.quat_j * qa.quat_j;
      p_rk <= qa.quat_real * qa.quat_k;
      p_ij <= qa.quat_i * qa.quat_j;
      p_kk <= qa.quat_k * qa.quat_k;
      p_rj <= qa.quat_real * qa.quat_j;
      p_ik <= qa.quat_i * qa.quat_k;
    end
  end

  always_comb begin
    q_data.ry = (ARG_W'(p_ri) + ARG_W'(p_jk)) <<< 1;
    q_data.rx = ONE_A - ((ARG_W'(p_ii) + ARG_W'(p_jj)) <<< 1);
    q_data.yy = (ARG_W'(p_rk) + ARG_W'(p_ij)) <<< 1;
    q_data.yx = ONE_A - ((ARG_W'(p_jj) + ARG_W'(p_kk)) <<< 1);
    t  = (PA_W+2)'(p_rj) - (PA_W+2)'(p_ik);
    pa = ONE_P + (t <<< 1);
    pb = ONE_P - (t <<< 1);
    q_data.pa = pa[PA_W+1] ? '0 : pa[PA_W-1:0];
    q_data.pb = pb[PA_W+1] ? '0 : pb[PA_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/q2e_queue.sv =====
// ----------------------------------------------------------------------------
// q2e_queue: short queue between front and back
// Small register FIFO; the front stalls only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_queue import q2e_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire front_t wdata,
  output logic        q_full,
  input  wire logic   pop,
  output logic        q_empty,
  output front_t      rdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0]  LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CNW-1:0] DEP  = CNW'(QUEUE_DEPTH);

  front_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CNW-1:0]  count;

  assign q_full  = (count == DEP);
  assign q_empty = (count == '0);
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      count <= count + CNW'(push) - CNW'(pop);
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && q_empty))
    else $error("queue pop while empty");
  a_count: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CNW'($past(push)) - CNW'($past(pop)))
    else $error("queue count mismatch");

endmodule

`default_nettype wire

// ===== rtl/q2e_sqrt.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt: pipelined floor square root
// One result digit per stage, restoring digit-by-digit method.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt import q2e_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SQ_W-1:0]   arg,
  output logic [SQ_DIGITS-1:0]   root
);

  logic [SQ_W-1:0] a_q [SQ_DIGITS];
  logic [SQ_W-1:0] r_q [SQ_DIGITS];

  for (genvar k = 0; k < SQ_DIGITS; k++) begin : g_st
    localparam logic [SQ_W-1:0] BITK = SQ_W'(1) << (2 * (SQ_DIGITS - 1 - k));
    logic [SQ_W-1:0] a_in, r_in, trial;
    if (k == 0) begin : g_first
      assign a_in = arg;
      assign r_in = '0;
    end else begin : g_rest
      assign a_in = a_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign trial = r_in + BITK;
    always_ff @(posedge clk) begin
      if (en) begin
        if (a_in >= trial) begin
          a_q[k] <= a_in - trial;
          r_q[k] <= (r_in >> 1) + BITK;
        end else begin
          a_q[k] <= a_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root = r_q[SQ_DIGITS-1][SQ_DIGITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/q2e_cordic.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic: pipelined atan2
// Quadrant fold stage, then one vectoring micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic import q2e_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic signed [CW-1:0] x_in,
  output logic signed [ZW-1:0]      angle
);

  logic signed [CW-1:0] x_q [STAGES+1];
  logic signed [CW-1:0] y_q [STAGES+1];
  logic signed [ZW-1:0] z_q [STAGES+1];
  logic                 zf_q [STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zf_q[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_q[0] <= y_in;
          y_q[0] <= -x_in;
          z_q[0] <= DEG90;
        end else begin
          x_q[0] <= -y_in;
          y_q[0] <= x_in;
          z_q[0] <= -DEG90;
        end
      end else begin
        x_q[0] <= x_in;
        y_q[0] <= y_in;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 1; i <= STAGES; i++) begin : g_st
    localparam logic signed [ZW-1:0] ATN = atan_deg(i - 1);
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i-1] >>> (i - 1);
    assign ys = y_q[i-1] >>> (i - 1);
    always_ff @(posedge clk) begin
      if (en) begin
        zf_q[i] <= zf_q[i-1];
        if (y_q[i-1] >= 0) begin
          x_q[i] <= x_q[i-1] + ys;
          y_q[i] <= y_q[i-1] - xs;
          z_q[i] <= z_q[i-1] + ATN;
        end else begin
          x_q[i] <= x_q[i-1] - ys;
          y_q[i] <= y_q[i-1] + xs;
          z_q[i] <= z_q[i-1] - ATN;
        end
      end
    end
  end

  assign angle = zf_q[STAGES] ? '0 : z_q[STAGES];

endmodule

`default_nettype wire

// ===== rtl/q2e_back.sv =====
// ----------------------------------------------------------------------------
// q2e_back: angle pipeline and result register
// Square roots for pitch, three atan2 units, rounding, offset and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_back import q2e_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  input  wire front_t                  q_data,
  output logic                         q_pop,
  input  wire logic signed [CFG_W-1:0] roll_off,
  input  wire logic signed [CFG_W-1:0] pitch_off,
  output logic                         empty,
  input  wire logic                    pop,
  output euler_out_t                   euler
);

  localparam int L = SQ_DIGITS + 1 + STAGES;

  logic en, take, out_valid;
  logic [L-1:0] vld;
  logic [SQ_DIGITS-1:0] sa, sb;
  logic signed [ARG_W-1:0] d_ry [SQ_DIGITS];
  logic signed [ARG_W-1:0] d_rx [SQ_DIGITS];
  logic signed [ARG_W-1:0] d_yy [SQ_DIGITS];
  logic signed [ARG_W-1:0] d_yx [SQ_DIGITS];
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
  logic signed [FW-1:0] zp;

  assign en    = !out_valid || pop;
  assign take  = en && !q_empty;
  assign q_pop = take;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[L-2:0], take};
      out_valid <= vld[L-1];
    end
  end

  q2e_sqrt u_sqrt_a (
    .clk (clk), .en (en),
    .arg ({(SQ_W - PA_W - 20)'(0), q_data.pa, 20'd0}),
    .root (sa)
  );

  q2e_sqrt u_sqrt_b (
    .clk (clk), .en (en),
    .arg ({(SQ_W - PA_W - 20)'(0), q_data.pb, 20'd0}),
    .root (sb)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_ry[0] <= q_data.ry;
      d_rx[0] <= q_data.rx;
      d_yy[0] <= q_data.yy;
      d_yx[0] <= q_data.yx;
      for (int k = 1; k < SQ_DIGITS; k++) begin
        d_ry[k] <= d_ry[k-1];
        d_rx[k] <= d_rx[k-1];
        d_yy[k] <= d_yy[k-1];
        d_yx[k] <= d_yx[k-1];
      end
    end
  end

  q2e_cordic #(.STAGES(STAGES)) u_roll (
    .clk (clk), .en (en),
    .y_in (CW'(d_ry[SQ_DIGITS-1])), .x_in (CW'(d_rx[SQ_DIGITS-1])),
    .angle (z_roll)
  );

  q2e_cordic #(.STAGES(STAGES)) u_pitch (
    .clk (clk), .en (en),
    .y_in ($signed({(CW - SQ_DIGITS)'(0), sa})),
    .x_in ($signed({(CW - SQ_DIGITS)'(0), sb})),
    .angle (z_pitch)
  );

  q2e_cordic #(.STAGES(STAGES)) u_yaw (
    .clk (clk), .en (en),
    .y_in (CW'(d_yy[SQ_DIGITS-1])), .x_in (CW'(d_yx[SQ_DIGITS-1])),
    .angle (z_yaw)
  );

  assign zp = (FW'(z_pitch) <<< 1) - DEG90_F;

  always_ff @(posedge clk) begin
    if (en) begin
      euler.roll_deg  <= finish(FW'(z_roll), roll_off);
      euler.pitch_deg <= finish(zp, pitch_off);
      euler.yaw_deg   <= finish(FW'(z_yaw), '0);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quaternion_to_euler_degrees_top.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_top: quaternion to roll/pitch/yaw in degrees
// Input queue side: push/full with a Q2.14 quaternion; an item transfers on
// push && !full. Result side: empty/pop; the oldest result (degrees, 7
// fraction bits) is shown while empty is low and transfers on pop && !empty.
// Configuration: wr_en/wr_index/wr_data writes roll_offset (0) and
// pitch_offset (1); other indexes are ignored. Write only while idle.
// Throughput: one quaternion per cycle, sustained, while results are taken.
// From input transfer to empty going low, an item passes the input and
// product registers, the queue, the 28 digit stages of the square root,
// the fold plus CORDIC stages of atan2 and the result register.
// When the receiver stalls, the result register holds and the back pipeline
// freezes; the front keeps filling the 4-entry queue, then raises full.
// Reset clears all valid state and loads the default calibration offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_to_euler_degrees_top import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire quat_in_t         quat,
  output logic                  empty,
  input  wire logic             pop,
  output euler_out_t            euler,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0] wr_data
);

  localparam int N_EFF = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  logic signed [CFG_W-1:0] roll_off, pitch_off;
  logic   q_full, q_empty, q_push, q_pop;
  front_t q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_off  <= ROLL_OFFSET_RST;
      pitch_off <= PITCH_OFFSET_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROLL_OFFSET:  roll_off  <= wr_data;
        REG_PITCH_OFFSET: pitch_off <= wr_data;
        default: ;
      endcase
    end
  end

  q2e_front u_front (
    .clk (clk), .rst (rst), .push (push), .full (full), .quat (quat),
    .q_full (q_full), .q_push (q_push), .q_data (q_wdata)
  );

  q2e_queue u_queue (
    .clk (clk), .rst (rst), .push (q_push), .wdata (q_wdata), .q_full (q_full),
    .pop (q_pop), .q_empty (q_empty), .rdata (q_rdata)
  );

  q2e_back #(.STAGES(N_EFF)) u_back (
    .clk (clk), .rst (rst), .q_empty (q_empty), .q_data (q_rdata), .q_pop (q_pop),
    .roll_off (roll_off), .pitch_off (pitch_off),
    .empty (empty), .pop (pop), .euler (euler)
  );

endmodule

`default_nettype wire

// ===== tb/sv/quaternion_to_euler_degrees_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_check: result predictor and scoreboard
// Watches the quaternion and Euler queue ports and the register write port.
// Each accepted quaternion is converted to roll/pitch/yaw with an independent
// model of the CORDIC atan2 and the digit-by-digit square root. Results are
// compared field by field, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_check import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             full,
  input  quat_in_t         quat,
  input  logic             empty,
  input  logic             pop,
  input  euler_out_t       euler,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0] wr_data,
  output int               errors,
  output int               outstanding
);

  localparam longint ONE_Q28  = longint'(1) << 28;
  localparam longint RIGHT_ANGLE = longint'(90) << 16;

  logic signed [CFG_W-1:0] roll_cal;
  logic signed [CFG_W-1:0] pitch_cal;
  euler_out_t              expected_euler[$];

  function automatic longint arc_angle(input longint y_in, input longint x_in);
    longint x, y, z, t, xs, ys;
    int     n;
    x = x_in;
    y = y_in;
    z = 0;
    n = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = RIGHT_ANGLE;
      end else begin
        t = x; x = -y; y = t; z = -RIGHT_ANGLE;
      end
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_deg(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_deg(i));
      end
    end
    return z;
  endfunction

  function automatic longint root_floor(input longint unsigned a_in);
    longint unsigned a, r, b;
    a = a_in;
    r = 0;
    b = longint'(1) << 62;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic logic signed [Q_W-1:0] to_q7(input longint ang, input longint off);
    longint v;
    v = ((ang + 256) >>> 9) + off;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[Q_W-1:0];
  endfunction

  function automatic euler_out_t convert(input quat_in_t q);
    longint qr, qi, qj, qk, ry, rx, yy, yx, t, pa, pb, sa, sb, pitch;
    euler_out_t e;
    qr = longint'(q.quat_real);
    qi = longint'(q.quat_i);
    qj = longint'(q.quat_j);
    qk = longint'(q.quat_k);
    ry = 2 * (qr * qi + qj * qk);
    rx = ONE_Q28 - 2 * (qi * qi + qj * qj);
    yy = 2 * (qr * qk + qi * qj);
    yx = ONE_Q28 - 2 * (qj * qj + qk * qk);
    t  = qr * qj - qi * qk;
    pa = ONE_Q28 + 2 * t;
    pb = ONE_Q28 - 2 * t;
    if (pa < 0) pa = 0;
    if (pb < 0) pb = 0;
    sa = root_floor(longint'(pa) << 20);
    sb = root_floor(longint'(pb) << 20);
    pitch = 2 * arc_angle(sa, sb) - RIGHT_ANGLE;
    e.roll_deg  = to_q7(arc_angle(ry, rx), longint'(roll_cal));
    e.pitch_deg = to_q7(pitch, longint'(pitch_cal));
    e.yaw_deg   = to_q7(arc_angle(yy, yx), 0);
    return e;
  endfunction

  assign outstanding = expected_euler.size();

  always @(posedge clk) begin
    euler_out_t e;
    if (rst) begin
      roll_cal  = ROLL_OFFSET_RST;
      pitch_cal = PITCH_OFFSET_RST;
      expected_euler.delete();
      errors = 0;
    end else begin
      if (push && !full) expected_euler.push_back(convert(quat));
      if (pop && !empty) begin
        if (expected_euler.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transfer %h", $time, euler);
        end else begin
          e = expected_euler.pop_front();
          if (e.roll_deg !== euler.roll_deg) begin
            errors++;
            $display("%0t: roll_deg expected %0d actual %0d", $time,
                     e.roll_deg, euler.roll_deg);
          end
          if (e.pitch_deg !== euler.pitch_deg) begin
            errors++;
            $display("%0t: pitch_deg expected %0d actual %0d", $time,
                     e.pitch_deg, euler.pitch_deg);
          end
          if (e.yaw_deg !== euler.yaw_deg) begin
            errors++;
            $display("%0t: yaw_deg expected %0d actual %0d", $time,
                     e.yaw_deg, euler.yaw_deg);
          end
        end
      end
      if (wr_en) begin
        if (wr_index == REG_ROLL_OFFSET) roll_cal = wr_data;
        else if (wr_index == REG_PITCH_OFFSET) pitch_cal = wr_data;
      end
    end
  end

endmodule

// ===== tb/sv/quaternion_to_euler_degrees_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_top_test: stimulus and verdict
// Drives directed and random quaternions (normalized, near-normalized and
// raw) through four idling phases, writes the calibration offsets between
// phases, including their extremes, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_top_test import q2e_pkg::*; ();

  localparam int LATENCY = 32 + CORDIC_STAGES_DEF;
  localparam int LIMIT   = 400000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  quat_in_t         quat = '0;
  logic             empty;
  logic             pop = 1'b0;
  euler_out_t       euler;
  logic             wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [CFG_W-1:0] wr_data = '0;
  int               errors;
  int               outstanding;
  int               send_idle_pct = 0;
  int               take_idle_pct = 0;
  int               cycles = 0;

  quaternion_to_euler_degrees_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .quat(quat),
    .empty(empty), .pop(pop), .euler(euler),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  quaternion_to_euler_degrees_check check (
    .clk(clk), .rst(rst), .push(push), .full(full), .quat(quat),
    .empty(empty), .pop(pop), .euler(euler),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("quaternion_to_euler_degrees_top_test: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    pop = !rst && ($urandom_range(99) >= take_idle_pct);
  end

  task automatic send_quat(input quat_in_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    quat = q;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic drain;
    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic quat_in_t make_quat(input int a, input int b, input int c, input int d);
    quat_in_t q;
    q.quat_real = a[15:0];
    q.quat_i    = b[15:0];
    q.quat_j    = c[15:0];
    q.quat_k    = d[15:0];
    return q;
  endfunction

  function automatic quat_in_t random_quat;
    real a, b, c, d, n, s;
    int  kind;
    kind = $urandom_range(99);
    if (kind < 25) return quat_in_t'({$urandom, $urandom});
    a = real'(int'($urandom_range(20000)) - 10000);
    b = real'(int'($urandom_range(20000)) - 10000);
    c = real'(int'($urandom_range(20000)) - 10000);
    d = real'(int'($urandom_range(20000)) - 10000);
    if ($urandom_range(9) == 0) b = 0.0;
    if ($urandom_range(9) == 0) d = 0.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    s = (kind < 85) ? 16384.0 : real'($urandom_range(32000, 8000));
    return make_quat($rtoi(a * s / n), $rtoi(b * s / n), $rtoi(c * s / n),
                     $rtoi(d * s / n));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 21;
    take_idle_pct = 78;
    send_quat(make_quat(16384, 0, 0, 0));
    send_quat(make_quat(0, 0, 0, 0));
    send_quat(make_quat(32767, 32767, 32767, 32767));
    send_quat(make_quat(-32768, -32768, -32768, -32768));
    send_quat(make_quat(32767, -32768, 32767, -32768));
    send_quat(make_quat(-32768, 32767, -32768, 32767));
    send_quat(make_quat(0, 8192, 8192, 0));
    send_quat(make_quat(8192, -8192, 8192, 8192));
    send_quat(make_quat(11585, 0, 11585, 0));
    send_quat(make_quat(11585, 0, -11585, 0));
    send_quat(make_quat(32767, 0, 32767, 0));
    send_quat(make_quat(32767, 0, -32768, 0));
    send_quat(make_quat(0, 16384, 0, 0));
    send_quat(make_quat(0, 0, 16384, 0));
    send_quat(make_quat(0, 0, 0, 16384));
    send_quat(make_quat(0, -16384, 0, 0));
    send_quat(make_quat(0, 0, 0, -16384));
    send_quat(make_quat(1, -1, 1, -1));
    for (int i = 0; i < 200; i++) send_quat(random_quat());
    drain();

    write_reg(REG_ROLL_OFFSET, 12'h7FF);
    write_reg(REG_PITCH_OFFSET, 12'h800);
    write_reg(2'd2, 12'h555);
    write_reg(2'd3, 12'hAAA);
    send_idle_pct = 78;
    take_idle_pct = 21;
    for (int i = 0; i < 200; i++) send_quat(random_quat());
    drain();

    write_reg(REG_ROLL_OFFSET, 12'h800);
    write_reg(REG_PITCH_OFFSET, 12'h7FF);
    send_idle_pct = 0;
    take_idle_pct = 0;
    for (int i = 0; i < 100; i++) send_quat(random_quat());
    drain();

    write_reg(REG_ROLL_OFFSET, CFG_W'($urandom));
    write_reg(REG_PITCH_OFFSET, CFG_W'($urandom));
    for (int i = 0; i < 100; i++) send_quat(random_quat());
    drain();

    if (errors == 0 && outstanding == 0) begin
      $display("quaternion_to_euler_degrees_top_test: clean");
    end else begin
      $display("quaternion_to_euler_degrees_top_test: errors");
    end
    $finish;
  end

endmodule
